// ===== design/pid_controller_clamped_unit_macros.svh =====
// Assertion macros shared by the PID controller checker.
`ifndef PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define PCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcc checker: next-cycle property failed");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define PCC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcc checker: same-cycle property failed");

// Consequent must hold in the cycle after reset is seen.
`define PCC_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("pcc checker: reset property failed");

`endif

// ===== design/pcc_pkg.sv =====
// Shared types, widths and codes for the clamped PID controller.
package pcc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int BOUND_W   = 31;
  localparam int OPND_W    = DATA_W + 1;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int DVD_W     = OPND_W + FRAC_BITS;
  localparam int MUL_CNT_W = $clog2(OPND_W);
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int CFG_IDX_W = 3;

  localparam logic MODE_STEP  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_BOUND = 3'd3,
    REG_DRIVE_BOUND    = 3'd4
  } pcc_reg_t;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    logic        [DATA_W-1:0] time_step;
  } pcc_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     drive_clamped;
    logic                     integral_clamped;
  } pcc_out_t;

  typedef struct packed {
    logic                     start;
    logic signed [OPND_W-1:0] mplier;
    logic signed [OPND_W-1:0] mcand;
  } pcc_mul_req_t;

  typedef struct packed {
    logic              start;
    logic [OPND_W-1:0] mag;
    logic [DATA_W-1:0] dvs;
  } pcc_div_req_t;

endpackage

// ===== design/pid_controller_clamped_unit.sv =====
// Positional PID controller with integral and output clamps, signed Q16.16.
// A step request runs in two phases; a clear request skips both. In the first
// phase the bit-serial divider forms the derivative, one quotient bit per
// cycle, running beside two bit-serial multipliers (dt times error, kp times
// error); the divider is skipped when the time step is zero. The second phase
// is one pass of the same two multipliers (ki times integral, kd times
// derivative). One request is worked on at a time; the next is accepted while
// a finished result still waits in the output register.
module pid_controller_clamped_unit import pcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcc_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int ISUM_W = TERM_W + 1;
  localparam int DSUM_W = TERM_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_LAUNCH1, S_WAIT1, S_INTEG, S_LAUNCH2, S_WAIT2, S_SUM, S_FINISH
  } state_t;

  state_t state;

  logic signed [DATA_W-1:0] gain_p;
  logic signed [DATA_W-1:0] gain_i;
  logic signed [DATA_W-1:0] gain_d;
  logic [BOUND_W-1:0]       integral_bound;
  logic [BOUND_W-1:0]       drive_bound;

  logic signed [DATA_W-1:0] integral_sum;
  logic signed [DATA_W-1:0] previous_error;
  logic signed [DATA_W-1:0] err;
  logic [DATA_W-1:0]        dt;
  logic                     diff_neg;
  logic signed [TERM_W-1:0] p_term;
  logic signed [DATA_W-1:0] deriv;
  logic                     integ_hit;
  logic signed [DSUM_W-1:0] drive_sum;

  logic                     accept;
  logic signed [DATA_W:0]   raw_err;
  logic signed [DATA_W-1:0] sat_err;
  logic signed [DATA_W:0]   err_diff;
  logic                     diff_neg_next;
  logic [OPND_W-1:0]        err_mag;
  logic                     dt_zero;
  logic                     phase2;

  pcc_mul_req_t             mul_a_req;
  pcc_mul_req_t             mul_b_req;
  pcc_div_req_t             div_req;
  logic                     mul_a_busy;
  logic                     mul_b_busy;
  logic                     div_busy;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic [OPND_W-1:0]        div_quo;
  logic                     div_ovf;

  logic signed [TERM_W-1:0] term_a;
  logic signed [TERM_W-1:0] term_b;
  logic signed [ISUM_W-1:0] isum;
  logic signed [ISUM_W-1:0] ibound_w;
  logic                     i_over;
  logic                     i_under;
  logic signed [DATA_W-1:0] integral_next;
  logic                     q_sat;
  logic signed [DATA_W-1:0] deriv_next;
  logic signed [DSUM_W-1:0] drive_total;
  logic signed [DSUM_W-1:0] dbound_w;
  logic                     d_over;
  logic                     d_under;
  logic signed [DATA_W-1:0] drive_val;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Error with saturation to the 32-bit range.
  always_comb begin
    raw_err = (DATA_W + 1)'(in_data.setpoint) - (DATA_W + 1)'(in_data.measured);
    if (raw_err[DATA_W] != raw_err[DATA_W-1]) begin
      sat_err = raw_err[DATA_W] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                : {1'b0, {(DATA_W - 1){1'b1}}};
    end else begin
      sat_err = raw_err[DATA_W-1:0];
    end
  end

  always_comb begin
    err_diff      = (DATA_W + 1)'(err) - (DATA_W + 1)'(previous_error);
    diff_neg_next = err_diff[DATA_W];
    err_mag       = diff_neg_next ? -err_diff : err_diff;
    dt_zero       = (dt == '0);
    phase2        = (state == S_LAUNCH2);
  end

  // Phase one: A = dt * err, B = kp * err. Phase two: A = ki * I, B = kd * D.
  always_comb begin
    mul_a_req.start  = (state == S_LAUNCH1) || phase2;
    mul_a_req.mplier = phase2 ? OPND_W'(gain_i) : {1'b0, dt};
    mul_a_req.mcand  = phase2 ? OPND_W'(integral_sum) : OPND_W'(err);
    mul_b_req.start  = (state == S_LAUNCH1) || phase2;
    mul_b_req.mplier = phase2 ? OPND_W'(gain_d) : OPND_W'(gain_p);
    mul_b_req.mcand  = phase2 ? OPND_W'(deriv) : OPND_W'(err);
    div_req.start    = (state == S_LAUNCH1) && !dt_zero;
    div_req.mag      = err_mag;
    div_req.dvs      = dt;
  end

  pcc_mul u_mul_a (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_a_req),
    .busy (mul_a_busy),
    .prod (prod_a)
  );

  pcc_mul u_mul_b (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_b_req),
    .busy (mul_b_busy),
    .prod (prod_b)
  );

  pcc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .quo  (div_quo),
    .ovf  (div_ovf)
  );

  // Dropping the low fraction bits of a two's complement product floors it.
  assign term_a = $signed(prod_a[PROD_W-1:FRAC_BITS]);
  assign term_b = $signed(prod_b[PROD_W-1:FRAC_BITS]);

  always_comb begin
    isum     = ISUM_W'(integral_sum) + ISUM_W'(term_a);
    ibound_w = ISUM_W'($signed({1'b0, integral_bound}));
    i_over   = (isum > ibound_w);
    i_under  = (isum < -ibound_w);
    if (i_over) begin
      integral_next = {1'b0, integral_bound};
    end else if (i_under) begin
      integral_next = -$signed({1'b0, integral_bound});
    end else begin
      integral_next = isum[DATA_W-1:0];
    end
  end

  // The quotient is a magnitude; a negative result may reach one step
  // further than a positive one.
  always_comb begin
    if (diff_neg) begin
      q_sat = div_ovf || div_quo[OPND_W-1] ||
              (div_quo[DATA_W-1] && (div_quo[DATA_W-2:0] != '0));
    end else begin
      q_sat = div_ovf || div_quo[OPND_W-1] || div_quo[DATA_W-1];
    end
    if (dt_zero) begin
      deriv_next = '0;
    end else if (diff_neg) begin
      deriv_next = q_sat ? {1'b1, {(DATA_W - 1){1'b0}}} : -div_quo[DATA_W-1:0];
    end else begin
      deriv_next = q_sat ? {1'b0, {(DATA_W - 1){1'b1}}} : div_quo[DATA_W-1:0];
    end
  end

  always_comb begin
    drive_total = DSUM_W'(p_term) + DSUM_W'(term_a) + DSUM_W'(term_b);
    dbound_w    = DSUM_W'($signed({1'b0, drive_bound}));
    d_over      = (drive_sum > dbound_w);
    d_under     = (drive_sum < -dbound_w);
    if (d_over) begin
      drive_val = {1'b0, drive_bound};
    end else if (d_under) begin
      drive_val = -$signed({1'b0, drive_bound});
    end else begin
      drive_val = drive_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_bound <= '1;
      drive_bound    <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P:         gain_p <= cfg_data;
        REG_GAIN_I:         gain_i <= cfg_data;
        REG_GAIN_D:         gain_d <= cfg_data;
        REG_INTEGRAL_BOUND: integral_bound <= cfg_data[BOUND_W-1:0];
        REG_DRIVE_BOUND:    drive_bound <= cfg_data[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      if (accept) begin
        err <= sat_err;
        dt  <= in_data.time_step;
        if (in_data.mode == MODE_CLEAR) begin
          integral_sum   <= '0;
          previous_error <= '0;
          integ_hit      <= 1'b0;
          drive_sum      <= '0;
        end
      end
      if (state == S_LAUNCH1) begin
        diff_neg <= diff_neg_next;
      end
      if (state == S_INTEG) begin
        integral_sum   <= integral_next;
        integ_hit      <= i_over || i_under;
        previous_error <= err;
        p_term         <= term_b;
        deriv          <= deriv_next;
      end
      if (state == S_SUM) begin
        drive_sum <= drive_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In S_FINISH the result register is either reloaded or held below.
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (in_data.mode == MODE_CLEAR) ? S_FINISH : S_LAUNCH1;
          end
        end
        S_LAUNCH1: state <= S_WAIT1;
        S_WAIT1: begin
          if (!mul_a_busy && !mul_b_busy && !div_busy) begin
            state <= S_INTEG;
          end
        end
        S_INTEG:   state <= S_LAUNCH2;
        S_LAUNCH2: state <= S_WAIT2;
        S_WAIT2: begin
          if (!mul_a_busy && !mul_b_busy) begin
            state <= S_SUM;
          end
        end
        S_SUM:     state <= S_FINISH;
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid                 <= 1'b1;
            out_data.drive            <= drive_val;
            out_data.drive_clamped    <= d_over || d_under;
            out_data.integral_clamped <= integ_hit;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/pcc_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
module pcc_mul import pcc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  pcc_mul_req_t             req,
  output logic                     busy,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [OPND_W:0]   acc;
  logic        [OPND_W-1:0] lo;
  logic signed [OPND_W-1:0] mcand;
  logic [MUL_CNT_W-1:0]     cnt;
  logic                     last;
  logic signed [OPND_W+1:0] addend;
  logic signed [OPND_W+1:0] step_sum;

  // The multiplier's sign bit carries negative weight, so the last
  // partial product is subtracted.
  always_comb begin
    last = (cnt == MUL_CNT_W'(OPND_W - 1));
    if (!lo[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -((OPND_W + 2)'(mcand));
    end else begin
      addend = (OPND_W + 2)'(mcand);
    end
    step_sum = (OPND_W + 2)'(acc) + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= '0;
      lo    <= req.mplier;
      mcand <= req.mcand;
    end else if (busy) begin
      acc <= step_sum[OPND_W+1:1];
      lo  <= {step_sum[0], lo[OPND_W-1:1]};
    end
  end

  assign prod = {acc[OPND_W-1:0], lo};

endmodule

// ===== design/pcc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module pcc_div import pcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pcc_div_req_t      req,
  output logic              busy,
  output logic [OPND_W-1:0] quo,
  output logic              ovf
);

  logic [DATA_W-1:0]    rem;
  logic [OPND_W-1:0]    dvd;
  logic [DATA_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 last;
  logic [OPND_W-1:0]    rem_shift;
  logic [OPND_W:0]      trial;
  logic                 fits;
  logic [DATA_W-1:0]    rem_next;

  // The dividend is the magnitude followed by FRAC_BITS zeros; the zeros
  // come in as the magnitude register shifts empty.
  always_comb begin
    last      = (cnt == DIV_CNT_W'(DVD_W - 1));
    rem_shift = {rem, dvd[OPND_W-1]};
    trial     = {1'b0, rem_shift} - {2'b00, dvs};
    fits      = !trial[OPND_W];
    rem_next  = fits ? trial[DATA_W-1:0] : rem_shift[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.mag;
      dvs <= req.dvs;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[OPND_W-2:0], 1'b0};
      ovf <= ovf | quo[OPND_W-1];
      quo <= {quo[OPND_W-2:0], fits};
    end
  end

endmodule

// ===== design/pcc_checker.sv =====
// Port-level checker for the PID controller, bound to the top level.
`include "pid_controller_clamped_unit_macros.svh"

module pcc_checker import pcc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pcc_out_t out_data
);

  // The result register is empty after reset.
  `PCC_ASSERT_AFTER_RESET(a_reset_empty, !out_valid)

  // One request is worked on at a time: acceptance closes the input.
  `PCC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // Clamping is symmetric with a 31-bit bound, so the most negative code
  // can never appear.
  `PCC_ASSERT_SAME(a_drive_range, out_valid,
                   out_data.drive != {1'b1, {(DATA_W - 1){1'b0}}})

  // A stalled result holds.
  `PCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_data))

endmodule

bind pid_controller_clamped_unit pcc_checker u_pcc_checker (.*);

// ===== verif/pid_controller_clamped_unit_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the clamped PID unit: predicts each result from accepted requests and compares.
module pid_controller_clamped_unit_checker import pcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  pcc_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  pcc_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam longint S32_MAX = 64'sh7FFF_FFFF;
  localparam longint S32_MIN = -S32_MAX - 1;

  logic signed [DATA_W-1:0] kp, ki, kd;
  logic        [BOUND_W-1:0] integ_lim, drive_lim;
  logic signed [DATA_W-1:0] integ_acc, last_err;
  pcc_out_t                 pending_drives[$];

  function automatic longint clamp_mag(input longint x, input longint lim, output logic hit);
    hit = 1'b1;
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    hit = 1'b0;
    return x;
  endfunction

  // Advances the controller state by one request and returns the drive it produces.
  function automatic pcc_out_t compute_drive(input pcc_in_t req);
    pcc_out_t        res;
    longint          err, integ, diff, deriv, total;
    longint unsigned dt, mag, quo;
    logic            integ_hit, drive_hit;
    res = '0;
    if (req.mode == MODE_CLEAR) begin
      integ_acc = '0;
      last_err  = '0;
      return res;
    end
    err = longint'($signed(req.setpoint)) - longint'($signed(req.measured));
    if (err > S32_MAX) err = S32_MAX;
    if (err < S32_MIN) err = S32_MIN;
    dt = {32'b0, req.time_step};

    integ = longint'(integ_acc) + ((longint'(dt) * err) >>> FRAC_BITS);
    integ = clamp_mag(integ, longint'(integ_lim), integ_hit);

    // A zero time step gives no derivative; otherwise divide the magnitude and
    // restore the sign, truncating toward zero.
    if (dt == 0) begin
      deriv = 0;
    end else begin
      diff = err - longint'(last_err);
      mag  = (diff < 0) ? -diff : diff;
      quo  = (mag << FRAC_BITS) / dt;
      if (diff < 0) begin
        deriv = (quo > 64'h8000_0000) ? S32_MIN : -longint'(quo);
      end else begin
        deriv = (quo > 64'h7FFF_FFFF) ? S32_MAX : longint'(quo);
      end
    end

    total = ((longint'(kp) * err) >>> FRAC_BITS)
          + ((longint'(ki) * integ) >>> FRAC_BITS)
          + ((longint'(kd) * deriv) >>> FRAC_BITS);
    total = clamp_mag(total, longint'(drive_lim), drive_hit);

    integ_acc = integ[DATA_W-1:0];
    last_err  = err[DATA_W-1:0];
    res.drive            = total[DATA_W-1:0];
    res.drive_clamped    = drive_hit;
    res.integral_clamped = integ_hit;
    return res;
  endfunction

  always @(posedge clk) begin
    pcc_out_t want;
    if (rst) begin
      kp         = '0;
      ki         = '0;
      kd         = '0;
      integ_lim  = '1;
      drive_lim  = '1;
      integ_acc  = '0;
      last_err   = '0;
      fail_count = 0;
      pending_drives.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_drives.size() == 0) begin
          $error("result with no request waiting: drive %0d", $signed(out_data.drive));
          fail_count++;
        end else begin
          want = pending_drives.pop_front();
          if (out_data.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(out_data.drive));
            fail_count++;
          end
          if (out_data.drive_clamped !== want.drive_clamped) begin
            $error("drive_clamped: expected %0d, got %0d",
                   want.drive_clamped, out_data.drive_clamped);
            fail_count++;
          end
          if (out_data.integral_clamped !== want.integral_clamped) begin
            $error("integral_clamped: expected %0d, got %0d",
                   want.integral_clamped, out_data.integral_clamped);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:         kp = cfg_data;
          REG_GAIN_I:         ki = cfg_data;
          REG_GAIN_D:         kd = cfg_data;
          REG_INTEGRAL_BOUND: integ_lim = cfg_data[BOUND_W-1:0];
          REG_DRIVE_BOUND:    drive_lim = cfg_data[BOUND_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_drives.push_back(compute_drive(in_data));
      outstanding <= pending_drives.size();
    end
  end

endmodule

// ===== verif/pid_controller_clamped_unit_tb.sv =====
`timescale 1ns / 100ps
// Top-level bench for the clamped PID unit: clock, reset, request traffic and verdict.
module pid_controller_clamped_unit_tb;
  import pcc_pkg::*;

  localparam int CYCLE_LIMIT    = 1_500_000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_REQUESTS = 219;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  pcc_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pcc_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycles         = 0;
  int fail_count;
  int outstanding;

  always #4 clk = ~clk;

  pid_controller_clamped_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pid_controller_clamped_unit_checker drive_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pid_controller_clamped_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_request(input logic op, input logic [DATA_W-1:0] sp, ms, dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: op, setpoint: sp, measured: ms, time_step: dt};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_gains(input logic [DATA_W-1:0] p, i, d, ilim, dlim);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_INTEGRAL_BOUND, ilim);
    write_reg(REG_DRIVE_BOUND, dlim);
    // An index past the register map must leave every setting alone.
    write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(REG_DRIVE_BOUND) + 1)),
              $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_gain();
    logic [DATA_W-1:0] v;
    v = $urandom_range(32'h4_0000);
    case ($urandom_range(9))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0001_0000;
      4: return 32'hFFFF_0000;
      5: return $urandom;
      default: return ($urandom_range(1) == 0) ? v : -v;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_bound();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(32'h0100_0000, 32'h100);
    endcase
  endfunction

  // Mostly values near the given level so that the loop does not just saturate.
  function automatic logic [DATA_W-1:0] rand_level(input logic [DATA_W-1:0] near);
    case ($urandom_range(19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return near + $urandom_range(32'h6_0000) - 32'h3_0000;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_step_time();
    case ($urandom_range(19))
      0, 1: return '0;
      2: return 32'h1;
      3: return '1;
      4, 5, 6: return $urandom;
      default: return $urandom_range(32'h4_0000, 32'h100);
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] sp, base;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h7FFF_FFFF, 32'h0100_0000);
    send_request(MODE_CLEAR, $urandom, $urandom, $urandom);
    send_request(MODE_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    send_request(MODE_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_STEP, 32'h0002_0000, 32'h0001_0000, 32'h0);
    send_request(MODE_STEP, 32'h0005_0000, 32'h0005_0000, 32'h0001_0000);
    // A full-scale error jump over the smallest time step saturates the derivative.
    send_request(MODE_STEP, 32'h7FFF_FFFF, 32'h0, 32'h1);
    send_request(MODE_STEP, 32'h8000_0000, 32'h0, 32'h1);
    repeat (3) send_request(MODE_STEP, 32'h0010_0000, 32'hFFF0_0000, 32'h0100_0000);
    send_request(MODE_CLEAR, $urandom, $urandom, $urandom);
    send_request(MODE_STEP, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000);
    drain_results();

    load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_request(MODE_STEP, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000);
    send_request(MODE_STEP, 32'hFFFD_0000, 32'h0003_0000, 32'h0000_0100);
    send_request(MODE_STEP, 32'h0, 32'h0, 32'h0);
    drain_results();

    load_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF);
    repeat (3) send_request(MODE_STEP, 32'h0004_0000, 32'h0, 32'h0001_0000);
    repeat (3) send_request(MODE_STEP, 32'hFFFC_0000, 32'h0, 32'h0001_0000);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      if (ph == 1) begin
        load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      end else if (ph == 5) begin
        load_gains(rand_gain(), rand_gain(), rand_gain(), 32'h0, 32'h0);
      end else begin
        load_gains(rand_gain(), rand_gain(), rand_gain(), rand_bound(), rand_bound());
      end
      base = $urandom_range(32'h40_0000) - 32'h20_0000;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        // Let the pipeline run dry once per phase before carrying on.
        if (n == PHASE_REQUESTS / 2) drain_results();
        if ($urandom_range(19) == 0) begin
          send_request(MODE_CLEAR, $urandom, $urandom, $urandom);
        end else begin
          sp = rand_level(base);
          send_request(MODE_STEP, sp, rand_level(sp), rand_step_time());
        end
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("pid_controller_clamped_unit verification clean");
    end else begin
      $display("pid_controller_clamped_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== pid_controller_clamped_unit.f =====
+incdir+design
design/pcc_pkg.sv
design/pcc_mul.sv
design/pcc_div.sv
design/pid_controller_clamped_unit.sv
design/pcc_checker.sv
verif/pid_controller_clamped_unit_checker.sv
verif/pid_controller_clamped_unit_tb.sv
